### design/sgr_pkg.sv
package sgr_pkg;

  // Width of the group size register.
  localparam int unsigned CFG_W = 5;

  // Reset value of the group size register.
  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd2;

  // Flags that travel with each drain command from front to back.
  typedef struct packed {
    logic bank;       // buffer bank holding the group
    logic reverse;    // full group: drain newest first
    logic list_last;  // group closes the list
  } cmd_flags_t;

  localparam int unsigned FLAGS_W = $bits(cmd_flags_t);

  // Bank release from the back part to the front part.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

### design/sgr_in_if.sv
interface sgr_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

### design/sgr_out_if.sv
interface sgr_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value_res;
  logic                          run_end;
  logic                          list_end;

  modport source (output valid, output value_res, output run_end, output list_end,
                  input ready);
  modport sink (input valid, input value_res, input run_end, input list_end,
                output ready);
endinterface

### design/stream_group_reverser.sv
// Stream group reverser.
// in_stream carries list elements (value, is_last); a transaction moves one
// element. out_stream carries reordered elements (value_res, run_end,
// list_end). Each time group_size elements have gathered, they leave newest
// first as one burst; a partial group closed by is_last leaves in arrival
// order. run_end marks the final item of each burst, list_end the final item
// of the list. cfg_we/cfg_data write group_size (0 acts as 1, above MAX_GROUP
// acts as MAX_GROUP); write it only while the block is idle.
// Throughput: one input transaction per cycle while a buffer bank is free;
// two banks let one group fill while the previous one drains. The drain side
// gives one result per cycle within a burst while the output queue has room,
// and pauses between bursts while the next drain command is loaded from the
// command queue. A group's drain command goes through the command queue,
// then the command register, the buffer read register and the output queue.
// Reset (rst, synchronous) empties the bank fill, the command queue and the
// output queue and sets group_size to 2; buffer contents are left as they are.
// A stalled receiver fills the two-entry output queue, then holds the drain;
// once both banks are waiting to drain, in_stream.ready drops.
module stream_group_reverser #(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0] cfg_data,
  sgr_in_if.sink                    in_stream,
  sgr_out_if.source                 out_stream
);

  localparam int unsigned IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned CMD_W = CNT_W + sgr_pkg::FLAGS_W;

  // buffer write path, front to back
  logic                   wr_en;
  logic [IDX_W:0]         wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // drain commands
  logic                   cmd_push;
  logic [CNT_W-1:0]       cmd_count_in;
  sgr_pkg::cmd_flags_t    cmd_flags_in;
  logic                   cmd_full;
  logic                   cmd_pop;
  logic                   cmd_valid;
  logic [CMD_W-1:0]       cmd_head;
  sgr_pkg::release_t      bank_release;

  // Accept elements, fill the current bank, and post a drain command.
  sgr_front #(
    .MAX_GROUP   (MAX_GROUP),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_stream    (in_stream),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cmd_push     (cmd_push),
    .cmd_count    (cmd_count_in),
    .cmd_flags    (cmd_flags_in),
    .cmd_full     (cmd_full),
    .bank_release (bank_release)
  );

  // Hold pending drain commands; two banks never need more than two slots.
  sgr_cmd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_data  ({cmd_count_in, cmd_flags_in}),
    .full       (cmd_full),
    .pop        (cmd_pop),
    .head_valid (cmd_valid),
    .head_data  (cmd_head)
  );

  // Drain one bank per command, in the order the command asks.
  sgr_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cmd_valid    (cmd_valid),
    .cmd_count    (cmd_head[CMD_W-1:sgr_pkg::FLAGS_W]),
    .cmd_flags    (sgr_pkg::cmd_flags_t'(cmd_head[sgr_pkg::FLAGS_W-1:0])),
    .cmd_pop      (cmd_pop),
    .bank_release (bank_release),
    .out_stream   (out_stream)
  );

endmodule

### design/sgr_cmd_queue.sv
module sgr_cmd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

### design/sgr_front.sv
module sgr_front #(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0]      cfg_data,
  sgr_in_if.sink                         in_stream,
  // buffer write port
  output logic                           wr_en,
  output logic [IDX_W:0]                 wr_addr,
  output logic [VALUE_WIDTH-1:0]         wr_data,
  // drain command
  output logic                           cmd_push,
  output logic [CNT_W-1:0]               cmd_count,
  output sgr_pkg::cmd_flags_t            cmd_flags,
  input  logic                           cmd_full,
  input  sgr_pkg::release_t              bank_release
);

  logic [sgr_pkg::CFG_W-1:0] group_size;
  logic                      bank;
  logic [CNT_W-1:0]          fill;
  logic [1:0]                busy;

  logic                      accept;
  logic [CNT_W-1:0]          g_eff;
  logic [CNT_W-1:0]          n;
  logic                      full_group;
  logic                      flush;

  always_comb begin
    if (group_size == '0) begin
      g_eff = CNT_W'(1);
    end else if (int'(group_size) > int'(MAX_GROUP)) begin
      g_eff = CNT_W'(MAX_GROUP);
    end else begin
      g_eff = CNT_W'(group_size);
    end
  end

  assign in_stream.ready = !busy[bank] && !cmd_full;
  assign accept          = in_stream.valid && in_stream.ready;
  assign n               = fill + CNT_W'(1);
  assign full_group      = (n >= g_eff);
  assign flush           = accept && (full_group || in_stream.is_last);

  assign wr_en   = accept;
  assign wr_addr = {bank, fill[IDX_W-1:0]};
  assign wr_data = in_stream.value;

  assign cmd_push            = flush;
  assign cmd_count           = n;
  assign cmd_flags.bank      = bank;
  assign cmd_flags.reverse   = full_group;
  assign cmd_flags.list_last = in_stream.is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= sgr_pkg::GROUP_SIZE_RESET;
    end else if (cfg_we) begin
      group_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      fill <= '0;
      busy <= '0;
    end else begin
      if (flush) begin
        fill       <= '0;
        bank       <= !bank;
      end else if (accept) begin
        fill <= n;
      end
      for (int b = 0; b < 2; b++) begin
        if (flush && (bank == 1'(b))) begin
          busy[b] <= 1'b1;
        end else if (bank_release.valid && (bank_release.bank == 1'(b))) begin
          busy[b] <= 1'b0;
        end
      end
    end
  end

endmodule

### design/sgr_back.sv
module sgr_back #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  // buffer write port from the front part
  input  logic                   wr_en,
  input  logic [IDX_W:0]         wr_addr,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  // drain command
  input  logic                   cmd_valid,
  input  logic [CNT_W-1:0]       cmd_count,
  input  sgr_pkg::cmd_flags_t    cmd_flags,
  output logic                   cmd_pop,
  output sgr_pkg::release_t      bank_release,
  sgr_out_if.source              out_stream
);

  localparam int unsigned DEPTH = 2 << IDX_W;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic                   active;
  logic [CNT_W-1:0]       cur_count;
  sgr_pkg::cmd_flags_t    cur_flags;
  logic [CNT_W-1:0]       pos;

  logic                   issue;
  logic                   issue_final;
  logic [CNT_W-1:0]       rd_idx;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   inflight;
  logic                   tag_run;
  logic                   tag_list;

  // two-entry output queue
  logic [VALUE_WIDTH+1:0] oq [2];
  logic                   oq_wr;
  logic                   oq_rd;
  logic [1:0]             oq_count;
  logic                   pop;
  logic [2:0]             occ_after;

  assign pop       = out_stream.valid && out_stream.ready;
  assign occ_after = 3'(oq_count) + 3'(inflight) - 3'(pop);
  assign issue     = active && (occ_after < 3'd2);
  assign issue_final = (pos == cur_count - CNT_W'(1));
  assign rd_idx    = cur_flags.reverse ? (cur_count - CNT_W'(1) - pos) : pos;
  assign cmd_pop   = !active && cmd_valid;

  assign bank_release.valid = issue && issue_final;
  assign bank_release.bank  = cur_flags.bank;

  assign out_stream.valid     = (oq_count != 2'd0);
  assign out_stream.value_res = oq[oq_rd][VALUE_WIDTH+1:2];
  assign out_stream.run_end   = oq[oq_rd][1];
  assign out_stream.list_end  = oq[oq_rd][0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[{cur_flags.bank, rd_idx[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag_run  <= issue_final;
      tag_list <= issue_final && cur_flags.list_last;
    end
    if (inflight) begin
      oq[oq_wr] <= {rd_data, tag_run, tag_list};
    end
    if (cmd_pop) begin
      cur_count <= cmd_count;
      cur_flags <= cmd_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pos      <= '0;
      inflight <= 1'b0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      inflight <= issue;
      if (cmd_pop) begin
        active <= 1'b1;
        pos    <= '0;
      end else if (issue) begin
        pos <= pos + CNT_W'(1);
        if (issue_final) begin
          active <= 1'b0;
        end
      end
      if (inflight) begin
        oq_wr <= !oq_wr;
      end
      if (pop) begin
        oq_rd <= !oq_rd;
      end
      oq_count <= oq_count + 2'(inflight) - 2'(pop);
    end
  end

endmodule

### dv/sgr_checker.sv
`timescale 1ns / 1ps
module sgr_checker #(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0] cfg_data,
  sgr_in_if                         in_ch,
  sgr_out_if                        out_ch,
  output int unsigned               mismatches,
  output int unsigned               awaiting,
  output int unsigned               results_seen
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   run_end;
    logic                   list_end;
  } reordered_t;

  logic [VALUE_WIDTH-1:0]    group_buf [MAX_GROUP];
  int unsigned               fill;
  logic [sgr_pkg::CFG_W-1:0] group_size;
  reordered_t                reordered_q [$];

  initial begin
    mismatches   = 0;
    awaiting     = 0;
    results_seen = 0;
    fill         = 0;
    group_size   = sgr_pkg::GROUP_SIZE_RESET;
  end

  function automatic int unsigned effective_size(input logic [sgr_pkg::CFG_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_GROUP) return MAX_GROUP;
    return size;
  endfunction

  // Buffer one element and queue the burst it closes, if any.
  function automatic void regroup(input logic [VALUE_WIDTH-1:0] v, input logic last);
    int unsigned g;
    int unsigned n;
    g = effective_size(group_size);
    if (fill >= MAX_GROUP) fill = MAX_GROUP - 1;
    group_buf[fill] = v;
    fill++;
    n = fill;
    if (n >= g) begin
      for (int i = 0; i < n; i++) begin
        reordered_q.push_back(reordered_t'{group_buf[n-1-i], (i + 1 == n),
                                           (i + 1 == n) && last});
      end
      fill = 0;
    end else if (last) begin
      for (int i = 0; i < n; i++) begin
        reordered_q.push_back(reordered_t'{group_buf[i], (i + 1 == n), (i + 1 == n)});
      end
      fill = 0;
    end
  endfunction

  task automatic check_result();
    reordered_t want;
    if (reordered_q.size() == 0) begin
      $error("unexpected result: value_res %0d run_end %0b list_end %0b",
             $signed(out_ch.value_res), out_ch.run_end, out_ch.list_end);
      mismatches++;
      return;
    end
    want = reordered_q.pop_front();
    if (out_ch.value_res !== want.value) begin
      $error("value_res: expected %0d, got %0d", $signed(want.value),
             $signed(out_ch.value_res));
      mismatches++;
    end
    if (out_ch.run_end !== want.run_end) begin
      $error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
      mismatches++;
    end
    if (out_ch.list_end !== want.list_end) begin
      $error("list_end: expected %0b, got %0b", want.list_end, out_ch.list_end);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill       = 0;
      group_size = sgr_pkg::GROUP_SIZE_RESET;
      reordered_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        check_result();
      end
      // An element taken at the same edge as a write still sees the old size.
      if (in_ch.valid && in_ch.ready) regroup(in_ch.value, in_ch.is_last);
      if (cfg_we) group_size = cfg_data;
    end
    awaiting = reordered_q.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MAX_GROUP     = 16;
  localparam int unsigned VALUE_WIDTH   = 32;
  // Watchdog limit, set well beyond what the slowest run needs.
  localparam int unsigned CYCLE_LIMIT   = 300000;
  // Cycles to let an element that closes no group settle inside the block.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned PHASES        = 16;
  localparam int unsigned PHASE_ITEMS   = 14;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      cfg_we   = 1'b0;
  logic [sgr_pkg::CFG_W-1:0] cfg_data = '0;

  int unsigned src_idle_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned cycle_count  = 0;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned results_seen;

  // Group sizes per random phase: extremes, zero and oversized among them.
  int unsigned size_plan [PHASES] = '{1, 2, 3, 4, 16, 0, 5, 8, 31, 2, 3, 17, 6, 1, 4, 2};
  // Idling patterns, cycled through by phase: none, sender, receiver, both.
  int unsigned idle_src  [4] = '{0, 66, 0, 25};
  int unsigned idle_sink [4] = '{0, 0, 66, 25};

  sgr_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  sgr_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_ch ();

  stream_group_reverser #(
    .MAX_GROUP  (MAX_GROUP),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_stream (in_ch),
    .out_stream(out_ch)
  );

  sgr_checker #(
    .MAX_GROUP  (MAX_GROUP),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .awaiting    (awaiting),
    .results_seen(results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold every block input at a known value from time zero.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready  = 1'b0;
  end

  // Receiver: stall at random on every falling edge, at the current rate.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results still awaited", awaiting);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one element and hold it until the transaction completes. Idle
  // cycles come first, so valid changes at most once per falling edge.
  task automatic send_element(input logic [VALUE_WIDTH-1:0] v, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid, wait for every awaited result, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_group_size(input int unsigned size);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= size[sgr_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly random values, with the extremes mixed in often.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned p;
    int unsigned eff;
    int unsigned len;
    int unsigned cut;
    int unsigned phase_start;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset group size of two; the last element completes a full group.
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
    // Odd length: a single element is left over at the end of the list.
    send_element(32'd1, 1'b0);
    send_element(32'd2, 1'b0);
    send_element(32'd3, 1'b1);

    // Zero group size passes elements straight through.
    write_group_size(0);
    send_element(32'd5, 1'b0);
    send_element(32'hFFFF_FFFB, 1'b1);

    // Shrink the size while two elements are buffered: the next element
    // flushes all three, newest first.
    write_group_size(3);
    send_element(32'd10, 1'b0);
    send_element(32'd11, 1'b0);
    write_group_size(1);
    send_element(32'd12, 1'b0);
    send_element(32'd13, 1'b1);

    // Partial group closed by the last element leaves in arrival order.
    write_group_size(5);
    send_element(32'h1234_5678, 1'b0);
    send_element(32'h8765_4321, 1'b0);
    send_element(32'h0F0F_F0F0, 1'b1);

    // Random lists, one group size and one idling pattern per phase.
    for (p = 0; p < PHASES; p++) begin
      src_idle_pct = idle_src[p % 4];
      stall_pct    = idle_sink[p % 4];
      write_group_size(size_plan[p]);
      eff = (size_plan[p] == 0) ? 1 : (size_plan[p] > MAX_GROUP) ? MAX_GROUP : size_plan[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        len = $urandom_range(2 * eff + 1, 1);
        if (len > 1 && $urandom_range(7) == 0) begin
          // Break the list: change the size part way through, then restore.
          cut = $urandom_range(len - 1, 1);
          for (int i = 0; i < cut; i++) send_element(pick_value(), 1'b0);
          write_group_size($urandom_range(31));
          for (int i = cut; i < len; i++) send_element(pick_value(), i == len - 1);
          write_group_size(size_plan[p]);
        end else begin
          for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
        end
      end
    end

    // Drain everything, then give stray results time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d list elements and checked %0d reordered results", items_sent,
             results_seen);
    $display("over %0d group size writes and four idling patterns", cfg_writes);
    if (mismatches == 0 && awaiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/sgr_pkg.sv
design/sgr_in_if.sv
design/sgr_out_if.sv
design/sgr_cmd_queue.sv
design/sgr_front.sv
design/sgr_back.sv
design/stream_group_reverser.sv
dv/sgr_checker.sv
dv/tb.sv
